// ===== hdl/atac_pkg.sv =====
// Shared constants, types and the arctangent table for the tilt angle block.
package atac_pkg;

    localparam int CAL_LOG2          = 8;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_STEPS        = 24;
    localparam int CORDIC_STEPS      =
        (CORDIC_ITERATIONS < ATAN_STEPS) ? CORDIC_ITERATIONS : ATAN_STEPS;
    localparam int ANGLE_LIMIT       = 23040;
    localparam int CAL_COUNT_W       = 17;
    localparam int SQRT_STEPS        = 24;
    localparam int STEP_W            = 5;
    localparam int XW                = 28;
    localparam int ZW                = 25;
    localparam logic [15:0] YAW_GAIN_RESET = 16'd500;

    typedef enum logic [1:0] {
        MUL_X   = 2'd0,
        MUL_Y   = 2'd1,
        MUL_Z   = 2'd2,
        MUL_YAW = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic              load;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              cordic_init;
        logic              cordic_step;
        logic [STEP_W-1:0] step;
        logic              angle_save;
        logic              phase;
        logic              out_load;
    } atac_cmd_t;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:  v = 25'sd2949120;
            5'd1:  v = 25'sd1740967;
            5'd2:  v = 25'sd919879;
            5'd3:  v = 25'sd466945;
            5'd4:  v = 25'sd234379;
            5'd5:  v = 25'sd117304;
            5'd6:  v = 25'sd58666;
            5'd7:  v = 25'sd29335;
            5'd8:  v = 25'sd14668;
            5'd9:  v = 25'sd7334;
            5'd10: v = 25'sd3667;
            5'd11: v = 25'sd1833;
            5'd12: v = 25'sd917;
            5'd13: v = 25'sd458;
            5'd14: v = 25'sd229;
            5'd15: v = 25'sd115;
            5'd16: v = 25'sd57;
            5'd17: v = 25'sd29;
            5'd18: v = 25'sd14;
            5'd19: v = 25'sd7;
            5'd20: v = 25'sd4;
            5'd21: v = 25'sd2;
            5'd22: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/atac_ctrl.sv =====
// Sequencing state machine for the tilt angle block.
module atac_ctrl
    import atac_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output atac_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SQRT, S_CINIT, S_CORDIC, S_ANGLE, S_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              phase_reg, phase_next;
    logic              m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        phase_next   = phase_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_X;
        cmd.phase    = phase_reg;
        cmd.step     = cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    phase_next = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_en  = (cnt_reg < STEP_W'(4));
                cmd.mul_sel = mul_sel_t'(cnt_reg[1:0]);
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(5)) begin
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = S_CINIT;
                end
            end
            S_CINIT: begin
                cmd.cordic_init = 1'b1;
                cnt_next        = '0;
                state_next      = S_CORDIC;
            end
            S_CORDIC: begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE: begin
                cmd.angle_save = 1'b1;
                if (!phase_reg) begin
                    phase_next    = 1'b1;
                    cmd.sqrt_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_SQRT;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    phase_next   = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_MUL) else $error("accept did not start work");
    a_out_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg) else $error("result load lost");
    a_cordic_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CORDIC |-> cnt_reg < STEP_W'(CORDIC_STEPS))
        else $error("cordic step out of range");
    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !phase_reg) else $error("phase not cleared");

endmodule

// ===== hdl/atac_dp.sv =====
// Datapath: multiplier, square root, CORDIC, calibration and result registers.
module atac_dp
    import atac_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  atac_cmd_t          cmd,
    input  logic               cfg_wr,
    input  logic [15:0]        cfg_data,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic signed [15:0] s_gyro_z,
    input  logic               s_start_calibration,
    output logic signed [16:0] m_pitch_angle,
    output logic signed [16:0] m_roll_angle,
    output logic signed [15:0] m_yaw_rate,
    output logic               m_calibrating
);

    logic signed [15:0] ax_reg, ay_reg, az_reg, gz_reg;
    logic               start_reg;
    logic [15:0]        gain_reg;

    logic signed [16:0] ma, mb;
    logic signed [33:0] prod_reg;
    logic               mvld_reg;
    mul_sel_t           mtag_reg;
    logic [30:0]        sqx_reg, sqy_reg, sqz_reg;
    logic signed [15:0] yaw_reg;
    logic signed [17:0] yaw_q;

    logic [31:0]        sum;
    logic               roll_sum;
    logic [47:0]        rad_reg;
    logic [26:0]        rem_reg, rem_t, trial;
    logic [23:0]        root_reg;

    logic signed [XW-1:0] x_reg, y_reg, xs, ys;
    logic signed [ZW-1:0] z_reg, zr;
    logic signed [15:0]   num;
    logic signed [15:0]   angle, pitch_raw_reg, roll_raw_reg;

    logic signed [15:0]   pitch_off_reg, roll_off_reg;
    logic signed [31:0]   pacc_reg, racc_reg, pacc_next, racc_next;
    logic [CAL_COUNT_W-1:0] cnt_reg, cnt_next;
    logic                 active_reg, active_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= YAW_GAIN_RESET;
        end else if (cfg_wr) begin
            gain_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg    <= s_accel_x;
            ay_reg    <= s_accel_y;
            az_reg    <= s_accel_z;
            gz_reg    <= s_gyro_z;
            start_reg <= s_start_calibration;
        end
    end

    always_comb begin
        case (cmd.mul_sel)
            MUL_X:   begin ma = 17'(ax_reg); mb = 17'(ax_reg); end
            MUL_Y:   begin ma = 17'(ay_reg); mb = 17'(ay_reg); end
            MUL_Z:   begin ma = 17'(az_reg); mb = 17'(az_reg); end
            default: begin ma = 17'(gz_reg); mb = $signed({1'b0, gain_reg}); end
        endcase
    end

    assign yaw_q = prod_reg[33:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvld_reg <= 1'b0;
        end else begin
            mvld_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= ma * mb;
            mtag_reg <= cmd.mul_sel;
        end
        if (mvld_reg) begin
            case (mtag_reg)
                MUL_X:   sqx_reg <= prod_reg[30:0];
                MUL_Y:   sqy_reg <= prod_reg[30:0];
                MUL_Z:   sqz_reg <= prod_reg[30:0];
                default: begin
                    if (yaw_q > 18'sd32767) begin
                        yaw_reg <= 16'sh7fff;
                    end else if (yaw_q < -18'sd32768) begin
                        yaw_reg <= -16'sh8000;
                    end else begin
                        yaw_reg <= yaw_q[15:0];
                    end
                end
            endcase
        end
    end

    // load the roll radicand while the pitch angle is saved
    assign roll_sum = cmd.phase | cmd.angle_save;
    assign sum      = roll_sum ? (32'(sqx_reg) + 32'(sqz_reg))
                               : (32'(sqy_reg) + 32'(sqz_reg));
    assign rem_t    = {rem_reg[24:0], rad_reg[47:46]};
    assign trial    = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            rad_reg  <= {sum, 16'h0000};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg <= {rad_reg[45:0], 2'b00};
            if (rem_t >= trial) begin
                rem_reg  <= rem_t - trial;
                root_reg <= {root_reg[22:0], 1'b1};
            end else begin
                rem_reg  <= rem_t;
                root_reg <= {root_reg[22:0], 1'b0};
            end
        end
    end

    assign num = cmd.phase ? ay_reg : ax_reg;
    assign xs  = x_reg >>> cmd.step;
    assign ys  = y_reg >>> cmd.step;

    always_ff @(posedge aclk) begin
        if (cmd.cordic_init) begin
            x_reg <= $signed({4'b0000, root_reg});
            y_reg <= $signed({{(XW-24){num[15]}}, num, 8'h00});
            z_reg <= '0;
        end else if (cmd.cordic_step) begin
            if (!y_reg[XW-1]) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_lut(cmd.step);
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_lut(cmd.step);
            end
        end
    end

    assign zr = (z_reg + 25'sd128) >>> 8;

    always_comb begin
        if (num == 16'sd0) begin
            angle = '0;
        end else if (root_reg == '0) begin
            angle = num[15] ? -16'(ANGLE_LIMIT) : 16'(ANGLE_LIMIT);
        end else if (zr > 25'(ANGLE_LIMIT)) begin
            angle = 16'(ANGLE_LIMIT);
        end else if (zr < -25'(ANGLE_LIMIT)) begin
            angle = -16'(ANGLE_LIMIT);
        end else begin
            angle = zr[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.angle_save) begin
            if (cmd.phase) begin
                roll_raw_reg <= angle;
            end else begin
                pitch_raw_reg <= angle;
            end
        end
    end

    assign active_eff = start_reg | active_reg;
    assign pacc_next  = (start_reg ? 32'sd0 : pacc_reg) + 32'(pitch_raw_reg);
    assign racc_next  = (start_reg ? 32'sd0 : racc_reg) + 32'(roll_raw_reg);
    assign cnt_next   = (start_reg ? '0 : cnt_reg) + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_off_reg <= '0;
            roll_off_reg  <= '0;
            pacc_reg      <= '0;
            racc_reg      <= '0;
            cnt_reg       <= '0;
            active_reg    <= 1'b1;
        end else if (cmd.out_load && active_eff) begin
            if (cnt_next == CAL_COUNT_W'(1 << CAL_LOG2)) begin
                pitch_off_reg <= 16'(pacc_next >>> CAL_LOG2);
                roll_off_reg  <= 16'(racc_next >>> CAL_LOG2);
                pacc_reg      <= pacc_next;
                racc_reg      <= racc_next;
                cnt_reg       <= '0;
                active_reg    <= 1'b0;
            end else begin
                pacc_reg   <= pacc_next;
                racc_reg   <= racc_next;
                cnt_reg    <= cnt_next;
                active_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_pitch_angle <= 17'(pitch_raw_reg) - 17'(pitch_off_reg);
            m_roll_angle  <= 17'(roll_raw_reg) - 17'(roll_off_reg);
            m_yaw_rate    <= yaw_reg;
            m_calibrating <= active_eff;
        end
    end

endmodule

// ===== hdl/accel_tilt_angle_with_calibration.sv =====
// Top level of the accelerometer tilt angle block with offset calibration.
// Each request runs these steps from acceptance to a loaded result: four
// passes of one shared 17x17 multiplier, then for pitch and for roll a
// bit-serial square root, a setup state, a 16-step shared CORDIC vectoring
// unit and an angle finish state, and last the result load.
// A new request is accepted once the result is handed to the output register,
// which holds it until taken; no new request is taken while one is in work.
// After reset the first 256 requests are averaged into the angle offsets.
module accel_tilt_angle_with_calibration
    import atac_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic signed [15:0] s_gyro_z,
    input  logic               s_start_calibration,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_pitch_angle,
    output logic signed [16:0] m_roll_angle,
    output logic signed [15:0] m_yaw_rate,
    output logic               m_calibrating,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    atac_cmd_t cmd;

    assign cfg_ready = 1'b1;

    atac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    atac_dp u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .cfg_wr              (cfg_valid & cfg_ready),
        .cfg_data            (cfg_data),
        .s_accel_x           (s_accel_x),
        .s_accel_y           (s_accel_y),
        .s_accel_z           (s_accel_z),
        .s_gyro_z            (s_gyro_z),
        .s_start_calibration (s_start_calibration),
        .m_pitch_angle       (m_pitch_angle),
        .m_roll_angle        (m_roll_angle),
        .m_yaw_rate          (m_yaw_rate),
        .m_calibrating       (m_calibrating)
    );

endmodule

// ===== dv/tb_accel_tilt_angle_with_calibration.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the accelerometer tilt angle block with calibration.
module tb_accel_tilt_angle_with_calibration;
    import atac_pkg::*;

    localparam int N_RANDOM   = 1700;
    localparam int WATCHDOG   = 20000;
    localparam int N_DIRECTED = 16;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gz;
        logic               start;
    } sample_t;

    typedef struct packed {
        logic signed [16:0] pitch;
        logic signed [16:0] roll;
        logic signed [15:0] yaw;
        logic               cal;
    } tilt_t;

    typedef struct packed {
        sample_t smp;
        logic    known;
        tilt_t   res;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_accel_x;
    logic signed [15:0] s_accel_y;
    logic signed [15:0] s_accel_z;
    logic signed [15:0] s_gyro_z;
    logic               s_start_calibration;
    logic               m_valid;
    logic               m_ready;
    logic signed [16:0] m_pitch_angle;
    logic signed [16:0] m_roll_angle;
    logic signed [15:0] m_yaw_rate;
    logic               m_calibrating;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;

    accel_tilt_angle_with_calibration uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_accel_x(s_accel_x), .s_accel_y(s_accel_y), .s_accel_z(s_accel_z),
        .s_gyro_z(s_gyro_z), .s_start_calibration(s_start_calibration),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pitch_angle(m_pitch_angle), .m_roll_angle(m_roll_angle),
        .m_yaw_rate(m_yaw_rate), .m_calibrating(m_calibrating),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0]        gain;
    logic signed [31:0] p_off, r_off;
    longint             p_acc, r_acc;
    int                 cal_cnt;
    logic               cal_on;

    tilt_t  pending_tilt[$];
    logic   pending_known[$];
    tilt_t  pending_given[$];
    int     errors;
    int     idle_cycles;
    bit     rx_idle_on;
    bit     rx_hold;
    bit     done;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [31:0] tilt_angle(longint num, longint a, longint b);
        longint x, y, z, xs, ys, r, sq, rem, bitv, n;
        n = (a * a + b * b) <<< 16;
        sq = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > n) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (n >= sq + bitv) begin
                n = n - (sq + bitv);
                sq = (sq >>> 1) + bitv;
            end else begin
                sq = sq >>> 1;
            end
            bitv = bitv >>> 2;
        end
        x = sq;
        y = num * 256;
        z = 0;
        if (num == 0) return 0;
        if (x == 0) return (num > 0) ? ANGLE_LIMIT : -ANGLE_LIMIT;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(atan_lut(i[STEP_W-1:0]));
            end else begin
                x -= ys; y += xs; z -= longint'(atan_lut(i[STEP_W-1:0]));
            end
        end
        r = fshift(z + 128, 8);
        if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
        if (r < -ANGLE_LIMIT) r = -ANGLE_LIMIT;
        return r[31:0];
    endfunction

    function automatic tilt_t predict_tilt(sample_t s);
        tilt_t  t;
        longint pitch, roll, yaw;
        pitch = tilt_angle(s.ax, s.ay, s.az);
        roll  = tilt_angle(s.ay, s.ax, s.az);
        yaw   = fshift(longint'(s.gz) * longint'({1'b0, gain}), 16);
        if (yaw > 32767) yaw = 32767;
        if (yaw < -32768) yaw = -32768;
        t.pitch = 17'(pitch - p_off);
        t.roll  = 17'(roll - r_off);
        t.yaw   = yaw[15:0];
        t.cal   = 1'b0;
        if (s.start) begin
            cal_on = 1'b1; cal_cnt = 0; p_acc = 0; r_acc = 0;
        end
        if (cal_on) begin
            t.cal = 1'b1;
            p_acc += pitch;
            r_acc += roll;
            cal_cnt++;
            if (cal_cnt >= (1 << CAL_LOG2)) begin
                p_off = 32'(fshift(p_acc, CAL_LOG2));
                r_off = 32'(fshift(r_acc, CAL_LOG2));
                cal_on = 1'b0;
                cal_cnt = 0;
            end
        end
        return t;
    endfunction

    task automatic send_sample(sample_t s, logic known, tilt_t given, bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_accel_x           <= s.ax;
        s_accel_y           <= s.ay;
        s_accel_z           <= s.az;
        s_gyro_z            <= s.gz;
        s_start_calibration <= s.start;
        pending_tilt.push_back(predict_tilt(s));
        pending_known.push_back(known);
        pending_given.push_back(given);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_tilt.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_gain(logic [15:0] g);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        gain = g;
    endtask

    function automatic sample_t rand_sample(int mode);
        sample_t s;
        s.ax = 16'($urandom);
        s.ay = 16'($urandom);
        s.az = 16'($urandom);
        s.gz = 16'($urandom);
        if (mode == 1) begin
            s.ax = 16'($signed($urandom_range(0, 400)) - 200);
            s.ay = 16'($signed($urandom_range(0, 400)) - 200);
        end else if (mode == 2) begin
            s.az = 16'($signed($urandom_range(0, 4)) - 2);
        end
        s.start = ($urandom_range(0, 150) == 0);
        return s;
    endfunction

    // receiver side: random ready bursts, a long hold on request
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 6);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        tilt_t e;
        tilt_t g;
        logic  k;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tilt.size() == 0) begin
                $display("%0t: unexpected result pitch %0d roll %0d", $time,
                         m_pitch_angle, m_roll_angle);
                errors++;
            end else begin
                e = pending_tilt.pop_front();
                k = pending_known.pop_front();
                g = pending_given.pop_front();
                if (k) e = g;
                if (m_pitch_angle !== e.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
                             m_pitch_angle);
                    errors++;
                end
                if (m_roll_angle !== e.roll) begin
                    $display("%0t: roll expected %0d actual %0d", $time, e.roll,
                             m_roll_angle);
                    errors++;
                end
                if (m_yaw_rate !== e.yaw) begin
                    $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, m_yaw_rate);
                    errors++;
                end
                if (m_calibrating !== e.cal) begin
                    $display("%0t: calibrating expected %0b actual %0b", $time, e.cal,
                             m_calibrating);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready) || done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    dir_row_t directed[N_DIRECTED];

    initial begin
        tilt_t  z;
        sample_t s;
        z = '0;
        // known rows: all zero, extremes of gyro with gain 500
        directed[0]  = '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b1,
                         '{17'sd0, 17'sd0, 16'sd0, 1'b1}};
        directed[1]  = '{'{16'sd0, 16'sd0, 16'sd100, 16'sd32767, 1'b0}, 1'b1,
                         '{17'sd0, 17'sd0, 16'sd249, 1'b1}};
        directed[2]  = '{'{16'sd0, 16'sd0, -16'sd100, -16'sd32768, 1'b0}, 1'b1,
                         '{17'sd0, 17'sd0, -16'sd250, 1'b1}};
        directed[3]  = '{'{16'sd5, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, z};
        directed[4]  = '{'{-16'sd5, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1'b0, z};
        directed[5]  = '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd1, 1'b0}, 1'b0, z};
        directed[6]  = '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd1, 1'b0}, 1'b0, z};
        directed[7]  = '{'{16'sd32767, -16'sd32768, 16'sd0, 16'sd1000, 1'b0}, 1'b0, z};
        directed[8]  = '{'{16'sd0, 16'sd16384, -16'sd16384, 16'sd0, 1'b0}, 1'b0, z};
        directed[9]  = '{'{-16'sd1, -16'sd1, 16'sd1, 16'sd2, 1'b1}, 1'b0, z};
        directed[10] = '{'{16'sd1, 16'sd1, 16'sd0, -16'sd2, 1'b0}, 1'b0, z};
        directed[11] = '{'{16'sd21845, -16'sd21846, 16'sd10922, 16'sd12345, 1'b0}, 1'b0, z};
        directed[12] = '{'{-16'sd21846, 16'sd21845, -16'sd10923, -16'sd12345, 1'b1}, 1'b0, z};
        directed[13] = '{'{16'sd100, 16'sd0, 16'sd100, 16'sd0, 1'b0}, 1'b0, z};
        directed[14] = '{'{16'sd0, -16'sd100, 16'sd100, 16'sd0, 1'b0}, 1'b0, z};
        directed[15] = '{'{16'sd4096, 16'sd4096, 16'sd4096, 16'sd4096, 1'b0}, 1'b0, z};

        errors = 0; done = 1'b0; rx_idle_on = 1'b1; rx_hold = 1'b0;
        gain = YAW_GAIN_RESET; p_off = 0; r_off = 0; p_acc = 0; r_acc = 0;
        cal_cnt = 0; cal_on = 1'b1;
        aresetn = 1'b0;
        s_valid = 1'b0; s_accel_x = '0; s_accel_y = '0; s_accel_z = '0;
        s_gyro_z = '0; s_start_calibration = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_sample(directed[i].smp, directed[i].known, directed[i].res, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_gain(16'hFFFF);
                1: write_gain(16'h0000);
                2: write_gain(16'($urandom));
                default: write_gain(YAW_GAIN_RESET);
            endcase
            if (ph == 3) rx_idle_on = 1'b0;
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                if (ph == 1 && i == 20) rx_hold = 1'b1;
                s = rand_sample(i % 3);
                if (i == 0) s.start = 1'b1;
                send_sample(s, 1'b0, z, ph != 3);
            end
            wait_drained();
        end

        done = 1'b1;
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
